### src/chip8_instruction_executor_assert.svh
// Assertion macros for the instruction executor checker
`ifndef CHIP8_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define CHIP8_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define C8_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define C8_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### src/c8ie_pkg.sv
// Shared constants, codes and types of the instruction executor
package c8ie_pkg;
   localparam int MemDepthDef   = 4096;
   localparam int StackDepthDef = 16;
   localparam int ScreenWDef    = 64;
   localparam int ScreenHDef    = 32;

   localparam logic [2:0] CMD_STEP  = 3'd0;
   localparam logic [2:0] CMD_TICK  = 3'd1;
   localparam logic [2:0] CMD_WRITE = 3'd2;
   localparam logic [2:0] CMD_READ  = 3'd3;
   localparam logic [2:0] CMD_PIXEL = 3'd4;

   localparam logic CSR_PROGRAM_START = 1'b0;
   localparam logic CSR_FONT_BASE     = 1'b1;

   localparam logic [11:0] PROGRAM_START_RST = 12'd512;
   localparam logic [11:0] FONT_BASE_RST     = 12'd80;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [11:0] address;
      logic [7:0]  write_byte;
      logic [7:0]  random_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_value;
      logic [15:0] executed_opcode;
      logic [11:0] program_counter;
      logic        sound_active;
      logic        status;
   } rsp_type;

   // eight-bit ALU for 8xyn, shared by the sequencer
   typedef struct packed {
      logic [7:0] val;
      logic       flag;
      logic       ok;
   } alu_res_type;

   function automatic alu_res_type alu8(input logic [3:0] n, input logic [7:0] a,
                                        input logic [7:0] b);
      alu_res_type r;
      logic [8:0] s;
      r.ok = 1'b1; r.flag = 1'b0; r.val = a;
      s = {1'b0, a} + {1'b0, b};
      case (n)
         4'h0: r.val = b;
         4'h1: r.val = a | b;
         4'h2: r.val = a & b;
         4'h3: r.val = a ^ b;
         4'h4: begin r.val = s[7:0]; r.flag = s[8]; end
         4'h5: begin r.val = a - b; r.flag = (a > b); end
         4'h6: begin r.val = {1'b0, a[7:1]}; r.flag = a[0]; end
         4'h7: begin r.val = b - a; r.flag = (b > a); end
         4'hE: begin r.val = {a[6:0], 1'b0}; r.flag = a[7]; end
         default: r.ok = 1'b0;
      endcase
      return r;
   endfunction
endpackage

### src/c8ie_screen.sv
// 64x32 one-bit frame buffer, one pixel port with registered read
module c8ie_screen import c8ie_pkg::*; #(
   parameter int ScreenW = ScreenWDef,
   parameter int ScreenH = ScreenHDef,
   localparam int PixN = ScreenW * ScreenH,
   localparam int PixW = $clog2(PixN)
) (
   input  logic            clock,
   input  logic [PixW-1:0] addr,
   input  logic            we,
   input  logic            wdata,
   output logic            rdata
);
   logic mem [PixN];
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

### src/c8ie_memory.sv
// Program memory, one byte port with registered read
module c8ie_memory import c8ie_pkg::*; #(
   parameter int MemDepth = MemDepthDef,
   localparam int AW = $clog2(MemDepth)
) (
   input  logic          clock,
   input  logic [AW-1:0] addr,
   input  logic          we,
   input  logic [7:0]    wdata,
   output logic [7:0]    rdata
);
   logic [7:0] mem [MemDepth];
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

### src/chip8_instruction_executor.sv
// Top level: sequencer around program memory, frame buffer and a shared ALU
//  channel | dir | handshake          | payload
//  req_    | in  | req_valid/req_stall | cmd, address, write_byte, random_byte
//  rsp_    | out | rsp_valid/rsp_stall | read_value, executed_opcode, program_counter, ...
//  csr_    | in  | csr_valid/csr_ready | csr_index, csr_data
// One item at a time; a new item is taken only once the previous result has left.
// Tick and unknown commands go straight to the output state; writes and reads pass
// through memory or frame buffer states, a step through fetch and execute, and 8xyn,
// Fx33, Fx55, Fx65, Dxyn (per sprite row) and the 00E0 clear sweep add states of their own.
// After reset a clear pass over the 2048 pixels runs before the first item.
// The result waits in an output register while rsp_stall is high.
module chip8_instruction_executor import c8ie_pkg::*; #(
   parameter int MemDepth   = MemDepthDef,
   parameter int StackDepth = StackDepthDef,
   parameter int ScreenW    = ScreenWDef,
   parameter int ScreenH    = ScreenHDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic [11:0] req_address,
   input  logic [7:0]  req_write_byte,
   input  logic [7:0]  req_random_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_value,
   output logic [15:0] rsp_executed_opcode,
   output logic [11:0] rsp_program_counter,
   output logic        rsp_sound_active,
   output logic        rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [11:0] csr_data
);
   localparam int AW   = $clog2(MemDepth);
   localparam int PixN = ScreenW * ScreenH;
   localparam int PixW = $clog2(PixN);
   localparam int XW   = $clog2(ScreenW);
   localparam int YW   = $clog2(ScreenH);
   localparam int SW   = $clog2(StackDepth + 1);
   localparam int SIW  = $clog2(StackDepth);

   localparam logic [4:0] S_CLEAR = 5'd0,  S_IDLE = 5'd1,  S_F0 = 5'd2,  S_F1 = 5'd3,
      S_F2 = 5'd4, S_EXEC = 5'd5, S_MEMRD = 5'd6, S_MEMRD2 = 5'd7, S_PIXRD = 5'd8,
      S_PIXRD2 = 5'd9, S_OUT = 5'd10, S_DROW = 5'd11, S_DROW2 = 5'd12, S_DPIX = 5'd13,
      S_DPIX2 = 5'd14, S_DPIX3 = 5'd15, S_BLK = 5'd16, S_BLKRD = 5'd17,
      S_BLKRD2 = 5'd18, S_BCD = 5'd19, S_CLS = 5'd20, S_MEMRD3 = 5'd21,
      S_ALU2 = 5'd22;

   logic [4:0]  state_ff, state_in;
   req_type     req_ff, req_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  v_ff [16];
   logic [7:0]  v_in [16];
   logic [15:0] i_ff, i_in;
   logic [11:0] pc_ff, pc_in, pstart_ff, pstart_in, font_ff, font_in;
   logic [11:0] stk_ff [StackDepth];
   logic [SW-1:0] sp_ff, sp_in;
   logic [7:0]  dt_ff, dt_in, st_ff, st_in;
   logic [15:0] op_ff, op_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [2:0]  bit_ff, bit_in;
   logic [7:0]  row_ff, row_in;
   logic [7:0]  bcd_ff, bcd_in;
   logic [1:0]  bcdi_ff, bcdi_in;
   logic [PixW-1:0] clr_ff, clr_in;
   logic        stk_we;
   logic [15:0] bcd_prod;
   logic [7:0]  bcd_quo, bcd_rem;

   logic [AW-1:0] m_addr;
   logic          m_we;
   logic [7:0]    m_wdata, m_rdata;
   logic [PixW-1:0] p_addr;
   logic          p_we, p_wdata, p_rdata;

   c8ie_memory #(.MemDepth(MemDepth)) u_mem (.clock, .addr(m_addr), .we(m_we),
      .wdata(m_wdata), .rdata(m_rdata));
   c8ie_screen #(.ScreenW(ScreenW), .ScreenH(ScreenH)) u_scr (.clock, .addr(p_addr),
      .we(p_we), .wdata(p_wdata), .rdata(p_rdata));

   logic [3:0] ox, oy, on;
   logic [7:0] okk, vx, vy;
   alu_res_type alu;
   logic [XW-1:0] px;
   logic [YW-1:0] py;
   assign ox = op_ff[11:8];
   assign oy = op_ff[7:4];
   assign on = op_ff[3:0];
   assign okk = op_ff[7:0];
   assign vx = v_ff[ox];
   assign vy = v_ff[oy];
   assign alu = alu8(on, vx, vy);
   assign px = XW'(vx + {5'd0, bit_ff});
   assign py = YW'(vy + {4'd0, cnt_ff});

   // divide by ten through the reciprocal 205/2048, exact for one byte
   assign bcd_prod = {8'd0, bcd_ff} * 16'd205;
   assign bcd_quo = {3'd0, bcd_prod[15:11]};
   assign bcd_rem = bcd_ff - {bcd_quo[4:0], 3'b000} - {2'd0, bcd_quo[4:0], 1'b0};

   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_read_value = rsp_ff.read_value;
   assign rsp_executed_opcode = rsp_ff.executed_opcode;
   assign rsp_program_counter = rsp_ff.program_counter;
   assign rsp_sound_active = rsp_ff.sound_active;
   assign rsp_status = rsp_ff.status;

   always_comb begin
      state_in = state_ff; req_in = req_ff; rsp_in = rsp_ff; rsp_valid_in = rsp_valid_ff;
      for (int k = 0; k < 16; k++) v_in[k] = v_ff[k];
      i_in = i_ff; pc_in = pc_ff; pstart_in = pstart_ff; font_in = font_ff;
      sp_in = sp_ff; dt_in = dt_ff; st_in = st_ff; op_in = op_ff; cnt_in = cnt_ff;
      bit_in = bit_ff; row_in = row_ff; bcd_in = bcd_ff; bcdi_in = bcdi_ff;
      clr_in = clr_ff; stk_we = 1'b0;
      m_addr = req_ff.address[AW-1:0]; m_we = 1'b0; m_wdata = req_ff.write_byte;
      p_addr = clr_ff; p_we = 1'b0; p_wdata = 1'b0;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      case (state_ff)
         S_CLEAR, S_CLS: begin
            p_addr = clr_ff; p_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == PixW'(PixN - 1)) begin
               state_in = (state_ff == S_CLEAR) ? S_IDLE : S_OUT;
            end
         end
         S_IDLE: begin
            if (req_valid && !rsp_valid_ff) begin
               req_in = {req_cmd, req_address, req_write_byte, req_random_byte};
               rsp_in = '0;
               case (req_cmd)
                  CMD_STEP:  state_in = S_F0;
                  CMD_TICK: begin
                     if (dt_ff != 8'd0) dt_in = dt_ff - 8'd1;
                     if (st_ff != 8'd0) st_in = st_ff - 8'd1;
                     state_in = S_OUT;
                  end
                  CMD_WRITE: state_in = S_MEMRD3;
                  CMD_READ:  state_in = S_MEMRD;
                  CMD_PIXEL: state_in = S_PIXRD;
                  default:   state_in = S_OUT;
               endcase
            end
         end
         S_MEMRD3: begin m_we = 1'b1; state_in = S_OUT; end
         S_MEMRD: state_in = S_MEMRD2;
         S_MEMRD2: begin rsp_in.read_value = m_rdata; state_in = S_OUT; end
         S_PIXRD: begin p_addr = req_ff.address[PixW-1:0]; state_in = S_PIXRD2; end
         S_PIXRD2: begin
            rsp_in.read_value = (req_ff.address < 12'(PixN)) ? {7'd0, p_rdata} : 8'd0;
            state_in = S_OUT;
         end
         S_F0: begin m_addr = pc_ff[AW-1:0]; state_in = S_F1; end
         S_F1: begin m_addr = AW'(pc_ff + 12'd1); op_in[15:8] = m_rdata; state_in = S_F2; end
         S_F2: begin
            op_in[7:0] = m_rdata; pc_in = pc_ff + 12'd2; state_in = S_EXEC;
         end
         S_EXEC: begin
            rsp_in.executed_opcode = op_ff;
            state_in = S_OUT;
            case (op_ff[15:12])
               4'h0: begin
                  if (op_ff == 16'h00E0) begin clr_in = '0; state_in = S_CLS; end
                  else if (op_ff == 16'h00EE) begin
                     if (sp_ff != '0) begin
                        sp_in = sp_ff - 1'b1;
                        pc_in = stk_ff[SIW'(sp_ff - 1'b1)];
                     end
                  end else rsp_in.status = 1'b1;
               end
               4'h1: pc_in = op_ff[11:0];
               4'h2: begin
                  if (sp_ff < SW'(StackDepth)) begin stk_we = 1'b1; sp_in = sp_ff + 1'b1; end
                  pc_in = op_ff[11:0];
               end
               4'h3: if (vx == okk) pc_in = pc_ff + 12'd2;
               4'h4: if (vx != okk) pc_in = pc_ff + 12'd2;
               4'h5: if (vx == vy) pc_in = pc_ff + 12'd2;
               4'h6: v_in[ox] = okk;
               4'h7: v_in[ox] = vx + okk;
               4'h8: begin
                  // write the flag now, the result next cycle from the updated registers
                  if (alu.ok) begin
                     if (on != 4'h0 && on != 4'h1 && on != 4'h2 && on != 4'h3)
                        v_in[15] = {7'd0, alu.flag};
                     state_in = S_ALU2;
                  end else rsp_in.status = 1'b1;
               end
               4'h9: if (vx != vy) pc_in = pc_ff + 12'd2;
               4'hA: i_in = {4'd0, op_ff[11:0]};
               4'hB: pc_in = op_ff[11:0] + {4'd0, v_ff[0]};
               4'hC: v_in[ox] = req_ff.random_byte & okk;
               4'hD: begin
                  v_in[15] = 8'd0; cnt_in = '0;
                  state_in = (on == 4'd0) ? S_OUT : S_DROW;
               end
               4'hE: rsp_in.status = 1'b1;
               default: begin
                  case (okk)
                     8'h07: v_in[ox] = dt_ff;
                     8'h15: dt_in = vx;
                     8'h18: st_in = vx;
                     8'h1E: i_in = i_ff + {8'd0, vx};
                     8'h29: i_in = {4'd0, font_ff} + {10'd0, vx[3:0], 2'b00}
                                 + {12'd0, vx[3:0]};
                     8'h33: begin bcd_in = vx; bcdi_in = 2'd2; state_in = S_BCD; end
                     8'h55: begin cnt_in = '0; state_in = S_BLK; end
                     8'h65: begin cnt_in = '0; state_in = S_BLKRD; end
                     default: rsp_in.status = 1'b1;
                  endcase
               end
            endcase
         end
         S_ALU2: begin v_in[ox] = alu.val; state_in = S_OUT; end
         S_BCD: begin
            // peel one digit per cycle: ones, tens, hundreds
            m_addr = AW'(i_ff + {14'd0, bcdi_ff});
            m_we = 1'b1;
            m_wdata = (bcdi_ff == 2'd0) ? bcd_ff : bcd_rem;
            bcd_in = bcd_quo;
            bcdi_in = bcdi_ff - 2'd1;
            if (bcdi_ff == 2'd0) state_in = S_OUT;
         end
         S_BLK: begin
            m_addr = AW'(i_ff + {12'd0, cnt_ff});
            m_we = 1'b1; m_wdata = v_ff[cnt_ff];
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == ox) state_in = S_OUT;
         end
         S_BLKRD: begin m_addr = AW'(i_ff + {12'd0, cnt_ff}); state_in = S_BLKRD2; end
         S_BLKRD2: begin
            v_in[cnt_ff] = m_rdata; cnt_in = cnt_ff + 4'd1;
            state_in = (cnt_ff == ox) ? S_OUT : S_BLKRD;
         end
         S_DROW: begin m_addr = AW'(i_ff + {12'd0, cnt_ff}); state_in = S_DROW2; end
         S_DROW2: begin row_in = m_rdata; bit_in = '0; state_in = S_DPIX; end
         S_DPIX: begin p_addr = {py, px}; state_in = S_DPIX2; end
         S_DPIX2: begin
            p_addr = {py, px};
            if (row_ff[7]) begin
               p_we = 1'b1; p_wdata = ~p_rdata;
               if (p_rdata) v_in[15] = 8'd1;
            end
            state_in = S_DPIX3;
         end
         S_DPIX3: begin
            row_in = {row_ff[6:0], 1'b0};
            bit_in = bit_ff + 3'd1;
            if (bit_ff == 3'd7) begin
               cnt_in = cnt_ff + 4'd1;
               state_in = (cnt_ff + 4'd1 == on) ? S_OUT : S_DROW;
            end else state_in = S_DPIX;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in.program_counter = pc_ff;
               rsp_in.sound_active = (st_ff != 8'd0);
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (csr_valid) begin
         if (csr_index == CSR_PROGRAM_START) begin pstart_in = csr_data; pc_in = csr_data; end
         else font_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 16; k++) v_ff[k] <= 8'd0;
         i_ff <= '0; pc_ff <= PROGRAM_START_RST; pstart_ff <= PROGRAM_START_RST;
         font_ff <= FONT_BASE_RST; sp_ff <= '0; dt_ff <= '0; st_ff <= '0; clr_ff <= '0;
      end else begin
         state_ff <= state_in; rsp_valid_ff <= rsp_valid_in;
         for (int k = 0; k < 16; k++) v_ff[k] <= v_in[k];
         i_ff <= i_in; pc_ff <= pc_in; pstart_ff <= pstart_in; font_ff <= font_in;
         sp_ff <= sp_in; dt_ff <= dt_in; st_ff <= st_in; clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in; rsp_ff <= rsp_in; op_ff <= op_in; cnt_ff <= cnt_in;
      bit_ff <= bit_in; row_ff <= row_in; bcd_ff <= bcd_in; bcdi_ff <= bcdi_in;
      if (stk_we) stk_ff[sp_ff[SIW-1:0]] <= pc_ff;
   end
endmodule

### src/c8ie_checker.sv
// Port-level checker for the instruction executor, bound to the top level
`include "chip8_instruction_executor_assert.svh"
module c8ie_checker import c8ie_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_executed_opcode,
   input logic [7:0]  rsp_read_value
);
   `C8_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_read_value), "stalled result changed")
   `C8_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "accepted while busy")
   `C8_ASSERT_IMPL(a_rsp_blocks_req, clock, reset, rsp_valid, req_stall, "item taken while a result waits")
   `C8_ASSERT_NEXT(a_rsp_once, clock, reset, rsp_valid && !rsp_stall, !rsp_valid, "result repeated")
   `C8_ASSERT_IMPL(a_step_no_read, clock, reset, rsp_valid && rsp_executed_opcode != 16'd0, rsp_read_value == 8'd0, "step result with read value")
endmodule

bind chip8_instruction_executor c8ie_checker u_chk (.clock, .reset, .req_valid, .req_stall,
   .rsp_valid, .rsp_stall, .rsp_executed_opcode, .rsp_read_value);
